// ===== hdl/jfs_pkg.sv =====
`timescale 1ns / 1ps

package jfs_pkg;

    localparam int FIELD_W         = 32;
    localparam int EDGE_W          = FIELD_W + 1;
    localparam int FORCE_W         = 64;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int ACC_WIDTH_DEF   = 64;
    localparam int CROSS_WIDTH     = 48;
    localparam int QUEUE_DEPTH     = 2;

    typedef struct packed {
        logic [FIELD_W-1:0] vel_x;
        logic [FIELD_W-1:0] vel_y;
        logic [FIELD_W-1:0] vel_z;
        logic [FIELD_W-1:0] start_x;
        logic [FIELD_W-1:0] start_y;
        logic [FIELD_W-1:0] start_z;
        logic [FIELD_W-1:0] end_x;
        logic [FIELD_W-1:0] end_y;
        logic [FIELD_W-1:0] end_z;
        logic [FIELD_W-1:0] circulation;
        logic               last_segment;
    } t_in_item;

    typedef struct packed {
        logic [FORCE_W-1:0] force_x;
        logic [FORCE_W-1:0] force_y;
        logic [FORCE_W-1:0] force_z;
    } t_out_item;

    // One classified segment on its way to the force pipeline; index 0/1/2 = x/y/z.
    typedef struct packed {
        logic [2:0][FIELD_W-1:0] vel;
        logic [2:0][EDGE_W-1:0]  edge_vec;
        logic [FIELD_W-1:0]      circ;
        logic                    last;
    } t_seg;

endpackage

// ===== hdl/jfs_front.sv =====
`timescale 1ns / 1ps

module jfs_front #(
    parameter int COORD_WIDTH = jfs_pkg::COORD_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  jfs_pkg::t_in_item i_in_item,
    output jfs_pkg::t_seg    o_seg,
    output logic             o_push_valid,
    input  logic             i_push_ready
);
    import jfs_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic  r_valid, n_valid;
    t_seg  r_seg, n_seg;
    logic  accept;

    logic signed [CW-1:0] s_vel [3];
    logic signed [CW-1:0] s_beg [3];
    logic signed [CW-1:0] s_end [3];
    logic signed [CW-1:0] s_circ;
    logic signed [CW:0]   s_edge [3];

    assign o_in_ready   = !r_valid || i_push_ready;
    assign accept       = i_in_valid && o_in_ready;
    assign o_seg        = r_seg;
    assign o_push_valid = r_valid;

    // Read each coordinate as its low bits, sign extended.
    always_comb begin
        s_vel[0] = i_in_item.vel_x[CW-1:0];
        s_vel[1] = i_in_item.vel_y[CW-1:0];
        s_vel[2] = i_in_item.vel_z[CW-1:0];
        s_beg[0] = i_in_item.start_x[CW-1:0];
        s_beg[1] = i_in_item.start_y[CW-1:0];
        s_beg[2] = i_in_item.start_z[CW-1:0];
        s_end[0] = i_in_item.end_x[CW-1:0];
        s_end[1] = i_in_item.end_y[CW-1:0];
        s_end[2] = i_in_item.end_z[CW-1:0];
        s_circ   = i_in_item.circulation[CW-1:0];
        for (int i = 0; i < 3; i++) begin
            s_edge[i] = (CW+1)'(s_end[i]) - (CW+1)'(s_beg[i]);
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_seg   = r_seg;
        if (accept) begin
            n_valid = 1'b1;
            for (int i = 0; i < 3; i++) begin
                n_seg.vel[i]      = FIELD_W'(s_vel[i]);
                n_seg.edge_vec[i] = EDGE_W'(s_edge[i]);
            end
            n_seg.circ = FIELD_W'(s_circ);
            n_seg.last = i_in_item.last_segment;
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_seg <= n_seg;
    end

endmodule

// ===== hdl/jfs_fifo.sv =====
`timescale 1ns / 1ps

module jfs_fifo #(
    parameter int DEPTH = jfs_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  jfs_pkg::t_seg i_seg,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    output jfs_pkg::t_seg o_seg,
    output logic          o_pop_valid,
    input  logic          i_pop_ready
);
    import jfs_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    t_seg             r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr, n_wr;
    logic [IDX_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push, pop;

    assign o_push_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_seg        = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_mem[r_wr] <= i_seg;
        end
    end

endmodule

// ===== hdl/jfs_back.sv =====
`timescale 1ns / 1ps

module jfs_back #(
    parameter int COORD_WIDTH = jfs_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = jfs_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH   = jfs_pkg::ACC_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jfs_pkg::t_seg      i_seg,
    input  logic               i_seg_valid,
    output logic               o_seg_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output jfs_pkg::t_out_item o_out_item
);
    import jfs_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int AW    = ACC_WIDTH;
    localparam int XC    = CROSS_WIDTH;
    localparam int PW    = 2 * CW + 1;           // velocity times edge
    localparam int XT    = PW + 2;               // difference plus rounding headroom
    localparam int XR    = XT - F;
    localparam int XE    = (XR > XC) ? XR : XC;
    localparam int LO_W  = XC / 2;
    localparam int HI_W  = XC - LO_W;
    localparam int PLO_W = LO_W + 1 + CW;
    localparam int PHI_W = HI_W + CW;
    localparam int MW    = XC + CW;              // cross times circulation
    localparam int MT    = MW + 1;
    localparam int MR    = MT - F;
    localparam int ME    = (MR > AW) ? MR : AW;

    localparam logic signed [XT-1:0] HALF_X = XT'(1) << (F - 1);
    localparam logic signed [MT-1:0] HALF_M = MT'(1) << (F - 1);
    localparam logic signed [XC-1:0] X_MAX  = {1'b0, {(XC-1){1'b1}}};
    localparam logic signed [XC-1:0] X_MIN  = {1'b1, {(XC-1){1'b0}}};
    localparam logic signed [AW-1:0] A_MAX  = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] A_MIN  = {1'b1, {(AW-1){1'b0}}};

    logic                    adv;

    // Stage 1: six products of the cross product
    logic                    r_v1;
    logic signed [PW-1:0]    r_pa [3];
    logic signed [PW-1:0]    r_pb [3];
    logic signed [CW-1:0]    r_g1;
    logic                    r_l1;
    // Stage 2: rounded, saturated cross product
    logic                    r_v2;
    logic signed [XC-1:0]    r_cr [3];
    logic signed [CW-1:0]    r_g2;
    logic                    r_l2;
    // Stage 3: split products with the circulation
    logic                    r_v3;
    logic signed [PLO_W-1:0] r_plo [3];
    logic signed [PHI_W-1:0] r_phi [3];
    logic                    r_l3;
    // Stage 4: per-segment force
    logic                    r_v4;
    logic signed [AW-1:0]    r_f [3];
    logic                    r_l4;
    // Accumulators and result register
    logic signed [AW-1:0]    r_acc [3];
    logic signed [AW-1:0]    n_acc [3];
    logic signed [AW-1:0]    s_sum [3];
    logic                    r_out_valid;
    t_out_item               r_out;

    logic signed [CW-1:0]    s_v [3];
    logic signed [CW:0]      s_d [3];
    logic signed [CW-1:0]    s_g;
    logic signed [PW-1:0]    n_pa [3];
    logic signed [PW-1:0]    n_pb [3];
    logic signed [XC-1:0]    n_cr [3];
    logic signed [PLO_W-1:0] n_plo [3];
    logic signed [PHI_W-1:0] n_phi [3];
    logic signed [AW-1:0]    n_f [3];

    // Whole pipeline moves when the result register can take a beat.
    assign adv         = !r_out_valid || i_out_ready;
    assign o_seg_ready = adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_v[i] = i_seg.vel[i][CW-1:0];
            s_d[i] = i_seg.edge_vec[i][CW:0];
        end
        s_g = i_seg.circ[CW-1:0];
        n_pa[0] = s_v[1] * s_d[2];
        n_pb[0] = s_v[2] * s_d[1];
        n_pa[1] = s_v[2] * s_d[0];
        n_pb[1] = s_v[0] * s_d[2];
        n_pa[2] = s_v[0] * s_d[1];
        n_pb[2] = s_v[1] * s_d[0];
    end

    // Round half up, then saturate the cross product.
    always_comb begin
        logic signed [XT-1:0] t;
        logic signed [XE-1:0] e;
        logic [XE-XC:0]       top;
        for (int i = 0; i < 3; i++) begin
            t   = XT'(r_pa[i]) - XT'(r_pb[i]) + HALF_X;
            e   = XE'($signed(t[XT-1:F]));
            top = e[XE-1:XC-1];
            if (&top || ~|top) begin
                n_cr[i] = e[XC-1:0];
            end else begin
                n_cr[i] = e[XE-1] ? X_MIN : X_MAX;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_plo[i] = $signed({1'b0, r_cr[i][LO_W-1:0]}) * r_g2;
            n_phi[i] = $signed(r_cr[i][XC-1:LO_W]) * r_g2;
        end
    end

    // Recombine the halves, round and saturate the force.
    always_comb begin
        logic signed [MW-1:0] p;
        logic signed [MT-1:0] t;
        logic signed [ME-1:0] e;
        logic [ME-AW:0]       top;
        for (int i = 0; i < 3; i++) begin
            p   = (MW'(r_phi[i]) <<< LO_W) + MW'(r_plo[i]);
            t   = MT'(p) + HALF_M;
            e   = ME'($signed(t[MT-1:F]));
            top = e[ME-1:AW-1];
            if (&top || ~|top) begin
                n_f[i] = e[AW-1:0];
            end else begin
                n_f[i] = e[ME-1] ? A_MIN : A_MAX;
            end
        end
    end

    always_comb begin
        logic signed [AW:0] t;
        for (int i = 0; i < 3; i++) begin
            t = (AW+1)'(r_acc[i]) + (AW+1)'(r_f[i]);
            if (t[AW] != t[AW-1]) begin
                s_sum[i] = t[AW] ? A_MIN : A_MAX;
            end else begin
                s_sum[i] = t[AW-1:0];
            end
            n_acc[i] = r_acc[i];
            if (adv && r_v4) begin
                n_acc[i] = r_l4 ? '0 : s_sum[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= n_acc[i];
            end
            if (adv) begin
                r_v1        <= i_seg_valid;
                r_v2        <= r_v1;
                r_v3        <= r_v2;
                r_v4        <= r_v3;
                r_out_valid <= r_v4 && r_l4;
            end
        end
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_pa[i]  <= n_pa[i];
                r_pb[i]  <= n_pb[i];
                r_cr[i]  <= n_cr[i];
                r_plo[i] <= n_plo[i];
                r_phi[i] <= n_phi[i];
                r_f[i]   <= n_f[i];
            end
            r_g1 <= s_g;
            r_l1 <= i_seg.last;
            r_g2 <= r_g1;
            r_l2 <= r_l1;
            r_l3 <= r_l2;
            r_l4 <= r_l3;
            if (r_v4 && r_l4) begin
                r_out.force_x <= FORCE_W'(s_sum[0]);
                r_out.force_y <= FORCE_W'(s_sum[1]);
                r_out.force_z <= FORCE_W'(s_sum[2]);
            end
        end
    end

endmodule

// ===== hdl/joukowski_force_sum.sv =====
`timescale 1ns / 1ps

// Kutta-Joukowski force sum. Each input beat is one vortex segment (velocity,
// start and end point, circulation, all signed fixed point); the block adds
// circulation times (velocity x edge) into three saturating accumulators and,
// on the beat marked last_segment, delivers the summed force and clears them.
// One segment is taken per clock when the output side keeps up. A result
// passes from its last segment through one front register forming the edge
// vector, a two-entry segment queue, then four arithmetic stages (cross
// product multiply, round and saturate, split 24-bit by coordinate
// multiply, recombine and round) and the accumulate.
// A stalled output holds the whole arithmetic pipeline; the queue and front
// register keep taking segments until they are full.
module joukowski_force_sum #(
    parameter int COORD_WIDTH = jfs_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = jfs_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH   = jfs_pkg::ACC_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  jfs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output jfs_pkg::t_out_item o_out_item
);
    import jfs_pkg::*;

    t_seg front_seg;
    t_seg queue_seg;
    logic push_valid;
    logic push_ready;
    logic pop_valid;
    logic pop_ready;

    jfs_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_seg        (front_seg),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready)
    );

    jfs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seg        (front_seg),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .o_seg        (queue_seg),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready)
    );

    jfs_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .ACC_WIDTH   (ACC_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg       (queue_seg),
        .i_seg_valid (pop_valid),
        .o_seg_ready (pop_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== tb/tb_joukowski_force_sum.sv =====
`timescale 1ns / 1ps

module tb_joukowski_force_sum;

    import jfs_pkg::*;

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [31:0] MAXN = 32'h8000_0000;
    localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;
    localparam int RANDOM_SEGMENTS = 2000;
    localparam int CALM_FROM       = 1700;
    localparam int HOLD_AT         = 400;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct {
        t_in_item  seg;
        bit        typed;
        t_out_item want;
    } t_plan_row;

    logic      clk;
    logic      rst_n      = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_item  in_item    = '0;
    logic      out_ready  = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    // side band travelling with each beat: a hand-typed expectation, if any
    bit        row_typed  = 1'b0;
    t_out_item row_want   = '0;

    bit        calm       = 1'b0;
    bit        hold_off   = 1'b0;
    int        errors     = 0;
    int        cycles     = 0;
    int        segs_taken = 0;
    int        sums_seen  = 0;
    int        sums_clamp = 0;

    logic signed [127:0] acc_x = '0;
    logic signed [127:0] acc_y = '0;
    logic signed [127:0] acc_z = '0;
    t_out_item force_due[$];
    t_plan_row directed[$];

    joukowski_force_sum dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [127:0] coord(input logic [31:0] raw);
        logic signed [31:0] s;
        s = raw;
        return s;
    endfunction

    // half up, then arithmetic shift
    function automatic logic signed [127:0] round_q(input logic signed [127:0] v);
        return (v + (128'sd1 <<< (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
    endfunction

    function automatic logic signed [127:0] clamp(input logic signed [127:0] v,
                                                  input int w);
        logic signed [127:0] top;
        top = (128'sd1 <<< (w - 1)) - 128'sd1;
        if (v > top) return top;
        if (v < -top - 128'sd1) return -top - 128'sd1;
        return v;
    endfunction

    // circulation times (p*q - r*s), with the cross term held to 48 bits
    function automatic logic signed [127:0] segment_force(
        input logic signed [127:0] p, q, r, s, g);
        logic signed [127:0] cr;
        cr = clamp(round_q(p * q - r * s), CROSS_WIDTH);
        return clamp(round_q(cr * g), ACC_WIDTH_DEF);
    endfunction

    function automatic bit add_segment(input t_in_item it, output t_out_item sum);
        logic signed [127:0] vx, vy, vz, dx, dy, dz, g;
        vx = coord(it.vel_x);
        vy = coord(it.vel_y);
        vz = coord(it.vel_z);
        dx = coord(it.end_x) - coord(it.start_x);
        dy = coord(it.end_y) - coord(it.start_y);
        dz = coord(it.end_z) - coord(it.start_z);
        g  = coord(it.circulation);
        acc_x = clamp(acc_x + segment_force(vy, dz, vz, dy, g), ACC_WIDTH_DEF);
        acc_y = clamp(acc_y + segment_force(vz, dx, vx, dz, g), ACC_WIDTH_DEF);
        acc_z = clamp(acc_z + segment_force(vx, dy, vy, dx, g), ACC_WIDTH_DEF);
        sum.force_x = acc_x[63:0];
        sum.force_y = acc_y[63:0];
        sum.force_z = acc_z[63:0];
        if (!it.last_segment) return 1'b0;
        acc_x = '0;
        acc_y = '0;
        acc_z = '0;
        return 1'b1;
    endfunction

    function automatic t_in_item segment(
        input logic [31:0] vx, vy, vz, sx, sy, sz, ex, ey, ez, g,
        input logic last);
        t_in_item it;
        it.vel_x = vx;   it.vel_y = vy;   it.vel_z = vz;
        it.start_x = sx; it.start_y = sy; it.start_z = sz;
        it.end_x = ex;   it.end_y = ey;   it.end_z = ez;
        it.circulation = g;
        it.last_segment = last;
        return it;
    endfunction

    function automatic t_out_item force_vec(input logic [63:0] fx, fy, fz);
        t_out_item f;
        f.force_x = fx;
        f.force_y = fy;
        f.force_z = fz;
        return f;
    endfunction

    function automatic void plan(input t_in_item seg, input bit typed,
                                 input t_out_item want);
        t_plan_row r;
        r.seg = seg;
        r.typed = typed;
        r.want = want;
        directed.insert(directed.size(), r);
    endfunction

    function automatic logic [31:0] rand_coord(input int flavour);
        case (flavour)
            0, 1: return $urandom;
            2: begin
                if ($urandom_range(0, 1)) return 32'h0 - $urandom_range(0, 32'h0004_0000);
                return $urandom_range(0, 32'h0004_0000);
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: return MAXP;
                    1: return MAXN;
                    2: return 32'h0;
                    3: return 32'hFFFF_FFFF;
                    4: return ONE;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic offer_segment(input t_in_item seg, input bit typed,
                                 input t_out_item want);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_item   <= seg;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        segs_taken++;
    endtask

    // predict on every accepted segment, check every accepted force vector
    always @(posedge clk) begin
        t_out_item predicted, due;
        if (rst_n && in_valid && in_ready) begin
            if (add_segment(in_item, predicted))
                force_due.insert(force_due.size(), row_typed ? row_want : predicted);
        end
        if (rst_n && out_valid && out_ready) begin
            sums_seen++;
            if (out_item.force_x inside {SUM_MAX, SUM_MIN}
                || out_item.force_y inside {SUM_MAX, SUM_MIN}
                || out_item.force_z inside {SUM_MAX, SUM_MIN})
                sums_clamp++;
            if (force_due.size() == 0) begin
                errors++;
                $display("%0t: force vector with none expected: %h", $time, out_item);
            end else begin
                due = force_due.pop_front();
                if (out_item.force_x !== due.force_x) begin
                    errors++;
                    $display("%0t: force_x expected %h actual %h",
                             $time, due.force_x, out_item.force_x);
                end
                if (out_item.force_y !== due.force_y) begin
                    errors++;
                    $display("%0t: force_y expected %h actual %h",
                             $time, due.force_y, out_item.force_y);
                end
                if (out_item.force_z !== due.force_z) begin
                    errors++;
                    $display("%0t: force_z expected %h actual %h",
                             $time, due.force_z, out_item.force_z);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d force vectors outstanding",
                     $time, force_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output side: random back-pressure, one long hold-off to fill the block
    initial begin
        int n;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off) begin
                hold_off = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                n = $urandom_range(1, 17);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial begin
        t_out_item none;
        int        sent;
        int        len;
        int        flav;
        none = '0;

        plan(segment(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1, force_vec(0, 0, 0));
        plan(segment(ONE, 0, 0, 0, 0, 0, 0, ONE, 0, ONE, 1'b1), 1'b1,
             force_vec(0, 0, 64'h1_0000));
        plan(segment(0, ONE, 0, 0, 0, 0, 0, 0, ONE, ONE, 1'b1), 1'b1,
             force_vec(64'h1_0000, 0, 0));
        plan(segment(0, 0, ONE, 0, 0, 0, ONE, 0, 0, ONE, 1'b1), 1'b1,
             force_vec(0, 64'h1_0000, 0));
        plan(segment(ONE, 0, 0, 0, 0, 0, 0, ONE, 0, 32'hFFFF_0000, 1'b1), 1'b1,
             force_vec(0, 0, 64'hFFFF_FFFF_FFFF_0000));
        // a non-final segment still counts towards the next sum
        plan(segment(ONE, 0, 0, 0, 0, 0, 0, ONE, 0, ONE, 1'b0), 1'b0, none);
        plan(segment(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1,
             force_vec(0, 0, 64'h1_0000));
        // exact half rounds up, negative half rounds to zero
        plan(segment(32'h1, 0, 0, 0, 0, 0, 0, 32'h8000, 0, ONE, 1'b1), 1'b1,
             force_vec(0, 0, 64'h1));
        plan(segment(32'h1, 0, 0, 0, 0, 0, 0, 32'hFFFF_8000, 0, ONE, 1'b1), 1'b1,
             force_vec(0, 0, 0));
        // cross product pinned at its 48-bit limit
        plan(segment(MAXP, MAXP, 0, MAXP, MAXN, 0, MAXN, MAXP, 0, MAXN, 1'b1), 1'b1,
             force_vec(0, 0, 64'hC000_0000_0000_8000));
        // accumulator runs into both rails
        plan(segment(MAXP, MAXP, 0, MAXP, MAXN, 0, MAXN, MAXP, 0, MAXP, 1'b0), 1'b0, none);
        plan(segment(MAXP, MAXP, 0, MAXP, MAXN, 0, MAXN, MAXP, 0, MAXP, 1'b0), 1'b0, none);
        plan(segment(MAXP, MAXP, 0, MAXP, MAXN, 0, MAXN, MAXP, 0, MAXP, 1'b1), 1'b1,
             force_vec(0, 0, SUM_MAX));
        plan(segment(MAXP, MAXP, 0, MAXP, MAXN, 0, MAXN, MAXP, 0, MAXN, 1'b0), 1'b0, none);
        plan(segment(MAXP, MAXP, 0, MAXP, MAXN, 0, MAXN, MAXP, 0, MAXN, 1'b0), 1'b0, none);
        plan(segment(MAXP, MAXP, 0, MAXP, MAXN, 0, MAXN, MAXP, 0, MAXN, 1'b1), 1'b1,
             force_vec(0, 0, SUM_MIN));
        // cleared after a saturated sum
        plan(segment(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1, force_vec(0, 0, 0));
        plan(segment(MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, 1'b0),
             1'b0, none);
        plan(segment(MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, 1'b1),
             1'b0, none);
        plan(segment(MAXN, MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, MAXN, 1'b1),
             1'b0, none);
        plan(segment(MAXN, MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, MAXP, 1'b1),
             1'b0, none);
        plan(segment(MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, 1'b0),
             1'b0, none);
        plan(segment(MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, 1'b1),
             1'b0, none);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            offer_segment(directed[i].seg, directed[i].typed, directed[i].want);

        sent = 0;
        while (sent < RANDOM_SEGMENTS) begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                               : $urandom_range(1, 6);
            flav = $urandom_range(0, 3);
            for (int k = 0; k < len; k++) begin
                if (sent == HOLD_AT) hold_off = 1'b1;
                if (sent == CALM_FROM) calm = 1'b1;
                offer_segment(segment(rand_coord(flav), rand_coord(flav), rand_coord(flav),
                                      rand_coord(flav), rand_coord(flav), rand_coord(flav),
                                      rand_coord(flav), rand_coord(flav), rand_coord(flav),
                                      rand_coord(flav), k == len - 1),
                              1'b0, none);
                sent++;
            end
        end
        in_valid <= 1'b0;

        // drain, then allow for the pipeline depth
        while (force_due.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        $display("run covered %0d segments and checked %0d force sums,", segs_taken,
                 sums_seen);
        $display("%0d of them clamped at an accumulator rail", sums_clamp);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
